FILE: design/alws_pkg.sv
// ----------------------------------------------------------------------------
// alws_pkg
// Shared types and constants for the array list with statistics.
// ----------------------------------------------------------------------------
package alws_pkg;

   // operation codes carried in req_tuser
   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   // fixed field widths
   localparam int OP_W    = 2;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 11;
   localparam int POS_W   = 10;
   localparam int REQ_W   = 48;   // value(32) count(11), padded to bytes
   localparam int RSP_W   = 104;  // 97 bits of fields, padded to bytes

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic load_plain;
      logic scan_init;
      logic scan_run;
      logic div_init;
      logic div_run;
      logic load_query;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       empty;
      logic       scan_done;
      logic       div_done;
   } status_type;

endpackage

FILE: design/array_list_with_statistics.sv
// ----------------------------------------------------------------------------
// array_list_with_statistics
// Linear array list with append, remove-from-front and statistics query.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. Append, remove and the unused code
// pass through the execute state, which loads the response register once
// the output is free; the next request is taken only after that. A query
// on a non-empty list walks the store through its single read port, then
// runs the one-bit-per-cycle divider that forms the mean, then waits in the
// finish state until the output is free. A new request is accepted while
// the previous response still waits in the output register. Appends fail
// once the tail reaches STORE_DEPTH; space freed by removes is not reused.
module array_list_with_statistics #(
   parameter int STORE_DEPTH = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [alws_pkg::REQ_W-1:0] req_tdata,  // value[31:0], count[42:32]
   input  logic [alws_pkg::OP_W-1:0]  req_tuser,  // operation[1:0]
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // ok[0], item_count[11:1], largest_value[43:12], largest_position[53:44],
   // even_count[64:54], mean_value[96:65]
   output logic [alws_pkg::RSP_W-1:0] rsp_tdata
);

   alws_pkg::cmd_type    cmd;
   alws_pkg::status_type status;

   alws_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   alws_dpath #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_op    (req_tuser),
      .req_value (req_tdata[alws_pkg::VALUE_W-1:0]),
      .req_count (req_tdata[alws_pkg::VALUE_W+alws_pkg::COUNT_W-1:alws_pkg::VALUE_W]),
      .status    (status),
      .rsp_data  (rsp_tdata)
   );

endmodule

FILE: design/alws_ctrl.sv
// ----------------------------------------------------------------------------
// alws_ctrl
// Controller: sequences append, remove and query transactions and owns the
// response valid flag.
// ----------------------------------------------------------------------------
module alws_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  alws_pkg::status_type status,
   output alws_pkg::cmd_type    cmd
);

   alws_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= alws_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         alws_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = alws_pkg::ST_EXEC;
            end
         end
         alws_pkg::ST_EXEC: begin
            if (status.op == alws_pkg::OP_QUERY && !status.empty) begin
               cmd.scan_init = 1'b1;
               state_in      = alws_pkg::ST_SCAN;
            end else if (out_free) begin
               cmd.load_plain = 1'b1;
               state_in       = alws_pkg::ST_IDLE;
            end
         end
         alws_pkg::ST_SCAN: begin
            if (status.scan_done) begin
               cmd.div_init = 1'b1;
               state_in     = alws_pkg::ST_DIV;
            end else begin
               cmd.scan_run = 1'b1;
            end
         end
         alws_pkg::ST_DIV: begin
            if (status.div_done) begin
               state_in = alws_pkg::ST_FINISH;
            end else begin
               cmd.div_run = 1'b1;
            end
         end
         alws_pkg::ST_FINISH: begin
            if (out_free) begin
               cmd.load_query = 1'b1;
               state_in       = alws_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = alws_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_plain || cmd.load_query) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

FILE: design/alws_dpath.sv
// ----------------------------------------------------------------------------
// alws_dpath
// Datapath: item store, head and tail indexes, scan accumulators, serial
// divider for the mean, and the response register.
// ----------------------------------------------------------------------------
module alws_dpath #(
   parameter int STORE_DEPTH = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  alws_pkg::cmd_type           cmd,
   input  logic [alws_pkg::OP_W-1:0]    req_op,
   input  logic [alws_pkg::VALUE_W-1:0] req_value,
   input  logic [alws_pkg::COUNT_W-1:0] req_count,
   output alws_pkg::status_type        status,
   output logic [alws_pkg::RSP_W-1:0]   rsp_data
);

   localparam int IDX_W  = $clog2(STORE_DEPTH + 1);
   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int SUM_W  = alws_pkg::VALUE_W + IDX_W;
   localparam int CW     = IDX_W + alws_pkg::COUNT_W;
   localparam int XW     = IDX_W + 16;
   localparam int DCNT_W = $clog2(SUM_W + 1);
   localparam logic [IDX_W-1:0]  DEPTH_IDX = IDX_W'(STORE_DEPTH);
   localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(SUM_W);
   localparam int PAD_W  = alws_pkg::RSP_W - 1 - 3 * alws_pkg::COUNT_W
                           - 2 * alws_pkg::VALUE_W - alws_pkg::POS_W + alws_pkg::COUNT_W;

   // store
   logic [alws_pkg::VALUE_W-1:0] mem [STORE_DEPTH];

   // captured request
   logic [alws_pkg::OP_W-1:0]    op_ff;
   logic [alws_pkg::VALUE_W-1:0] value_ff;
   logic [alws_pkg::COUNT_W-1:0] count_ff;

   // list indexes
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;

   // scan
   logic [IDX_W-1:0]             ptr_ff;
   logic                         rd_vld_ff;
   logic [ADDR_W-1:0]            rd_pos_ff;
   logic [alws_pkg::VALUE_W-1:0] rd_data_ff;
   logic                         first_ff;
   logic signed [alws_pkg::VALUE_W-1:0] big_ff;
   logic [ADDR_W-1:0]            big_pos_ff;
   logic [IDX_W-1:0]             evens_ff;
   logic signed [SUM_W-1:0]      sum_ff;

   // divider
   logic              sum_neg_ff;
   logic [SUM_W-1:0]  quo_ff;
   logic [IDX_W-1:0]  rem_ff;
   logic [DCNT_W-1:0] dcnt_ff;

   // response fields
   logic                         r_ok_ff;
   logic [alws_pkg::COUNT_W-1:0] r_items_ff;
   logic [alws_pkg::VALUE_W-1:0] r_big_ff;
   logic [alws_pkg::POS_W-1:0]   r_pos_ff;
   logic [alws_pkg::COUNT_W-1:0] r_evens_ff;
   logic [alws_pkg::VALUE_W-1:0] r_mean_ff;

   logic [IDX_W-1:0]  held, held_after;
   logic [CW-1:0]     count_x;
   logic              full, enough, plain_ok, scan_issue;
   logic [XW-1:0]     held_x, held_after_x, evens_x, pos_x;
   logic signed [alws_pkg::VALUE_W-1:0] rd_s;
   logic [IDX_W:0]    rem_sh;
   logic [IDX_W+1:0]  diff;
   logic [SUM_W-1:0]  mean_full;

   assign held       = tail_ff - head_ff;
   assign full       = (tail_ff == DEPTH_IDX);
   assign count_x    = CW'(count_ff);
   assign enough     = count_x <= CW'(held);
   assign scan_issue = cmd.scan_run && (ptr_ff != tail_ff);
   assign rd_s       = signed'(rd_data_ff);

   // side effects of append and remove
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      plain_ok = 1'b0;
      case (op_ff)
         alws_pkg::OP_APPEND: begin
            if (!full) begin
               tail_in  = tail_ff + 1'b1;
               plain_ok = 1'b1;
            end
         end
         alws_pkg::OP_REMOVE: begin
            if (enough) begin
               head_in  = head_ff + count_x[IDX_W-1:0];
               plain_ok = 1'b1;
            end
         end
         default: begin
            plain_ok = 1'b0;
         end
      endcase
   end

   assign held_after   = tail_in - head_in;
   assign held_after_x = XW'(held_after);
   assign held_x       = XW'(held);
   assign evens_x      = XW'(evens_ff);
   assign pos_x        = XW'(big_pos_ff);

   // restoring divide step: one quotient bit per cycle
   assign rem_sh    = {rem_ff, quo_ff[SUM_W-1]};
   assign diff      = {1'b0, rem_sh} - {2'b00, held};
   assign mean_full = sum_neg_ff ? (~quo_ff + 1'b1) : quo_ff;

   assign status.op        = op_ff;
   assign status.empty     = (held == '0);
   assign status.scan_done = (ptr_ff == tail_ff) && !rd_vld_ff;
   assign status.div_done  = (dcnt_ff == '0);

   // store write and registered read
   always_ff @(posedge clock) begin
      if (cmd.load_plain && op_ff == alws_pkg::OP_APPEND && !full) begin
         mem[tail_ff[ADDR_W-1:0]] <= value_ff;
      end
      if (scan_issue) begin
         rd_data_ff <= mem[ptr_ff[ADDR_W-1:0]];
      end
   end

   // control-like state: indexes and read-valid
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.load_plain) begin
            head_ff <= head_in;
            tail_ff <= tail_in;
         end
         if (cmd.scan_init) begin
            rd_vld_ff <= 1'b0;
         end else if (cmd.scan_run) begin
            rd_vld_ff <= scan_issue;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         value_ff <= req_value;
         count_ff <= req_count;
      end

      if (cmd.scan_init) begin
         ptr_ff   <= head_ff;
         first_ff <= 1'b1;
         evens_ff <= '0;
         sum_ff   <= '0;
      end else if (cmd.scan_run) begin
         if (scan_issue) begin
            ptr_ff    <= ptr_ff + 1'b1;
            rd_pos_ff <= ptr_ff[ADDR_W-1:0];
         end
         if (rd_vld_ff) begin
            first_ff <= 1'b0;
            // strict compare keeps the first of equal maxima
            if (first_ff || rd_s > big_ff) begin
               big_ff     <= rd_s;
               big_pos_ff <= rd_pos_ff;
            end
            if (!rd_data_ff[0]) begin
               evens_ff <= evens_ff + 1'b1;
            end
            sum_ff <= sum_ff + SUM_W'(rd_s);
         end
      end

      if (cmd.div_init) begin
         sum_neg_ff <= sum_ff[SUM_W-1];
         quo_ff     <= sum_ff[SUM_W-1] ? (~sum_ff + 1'b1) : sum_ff;
         rem_ff     <= '0;
         dcnt_ff    <= DIV_STEPS;
      end else if (cmd.div_run) begin
         if (!diff[IDX_W+1]) begin
            rem_ff <= diff[IDX_W-1:0];
         end else begin
            rem_ff <= rem_sh[IDX_W-1:0];
         end
         quo_ff  <= {quo_ff[SUM_W-2:0], !diff[IDX_W+1]};
         dcnt_ff <= dcnt_ff - 1'b1;
      end

      if (cmd.load_plain) begin
         r_ok_ff    <= plain_ok;
         r_items_ff <= held_after_x[alws_pkg::COUNT_W-1:0];
         r_big_ff   <= '0;
         r_pos_ff   <= '0;
         r_evens_ff <= '0;
         r_mean_ff  <= '0;
      end else if (cmd.load_query) begin
         r_ok_ff    <= 1'b1;
         r_items_ff <= held_x[alws_pkg::COUNT_W-1:0];
         r_big_ff   <= big_ff;
         r_pos_ff   <= pos_x[alws_pkg::POS_W-1:0];
         r_evens_ff <= evens_x[alws_pkg::COUNT_W-1:0];
         r_mean_ff  <= mean_full[alws_pkg::VALUE_W-1:0];
      end
   end

   assign rsp_data = {{PAD_W{1'b0}}, r_mean_ff, r_evens_ff, r_pos_ff, r_big_ff,
                      r_items_ff, r_ok_ff};

endmodule
